[rtl/core/eicr_pkg.sv]
`timescale 1ns / 1ps
package eicr_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int VEL_W    = 32;
    localparam int MASS_W   = 31;
    localparam int NRM_W    = 18;
    localparam int DEPTH_W  = 31;
    localparam int S_DATA_W = 264;
    localparam int M_DATA_W = 256;
    localparam int M_USER_W = 2;

    // tuser bit positions on the result channel
    localparam int USER_HIT = 0;
    localparam int USER_ERR = 1;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic [M_USER_W-1:0] user;
        logic [M_DATA_W-1:0] data;
    } out_beat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > SAT_HI) begin
            return SAT_HI[31:0];
        end else if (x < SAT_LO) begin
            return SAT_LO[31:0];
        end else begin
            return x[31:0];
        end
    endfunction

endpackage

[rtl/core/eicr_delay.sv]
`timescale 1ns / 1ps
module eicr_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

[rtl/core/eicr_div.sv]
`timescale 1ns / 1ps
// unsigned restoring divider, one quotient bit per stage
// quotient saturates to all ones when it does not fit in QUO_W bits
module eicr_div #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 32,
    parameter int QUO_W = 31
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] acc_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic             ovf_reg [QUO_W];

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] den_ext;
    logic             ovf_in;

    assign hi_ext  = CMP_W'(num[NUM_W-1:QUO_W]);
    assign den_ext = CMP_W'(den);
    assign ovf_in  = (hi_ext >= den_ext);

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_prev;
        logic [QUO_W-1:0] acc_prev;
        logic [DEN_W-1:0] den_prev;
        logic             ovf_prev;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] acc_next;

        if (k == 0) begin : g_first
            assign rem_prev = hi_ext[DEN_W-1:0];
            assign acc_prev = num[QUO_W-1:0];
            assign den_prev = den;
            assign ovf_prev = ovf_in;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign acc_prev = acc_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign ovf_prev = ovf_reg[k-1];
        end

        assign trial    = {rem_prev, acc_prev[QUO_W-1]};
        assign diff     = trial - {1'b0, den_prev};
        assign take     = (trial >= {1'b0, den_prev});
        assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign acc_next = {acc_prev[QUO_W-2:0], take};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                acc_reg[k] <= acc_next;
                den_reg[k] <= den_prev;
                ovf_reg[k] <= ovf_prev;
            end
        end
    end

    assign quo = ovf_reg[QUO_W-1] ? {QUO_W{1'b1}} : acc_reg[QUO_W-1];

endmodule

[rtl/core/eicr_skid.sv]
`timescale 1ns / 1ps
module eicr_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  eicr_pkg::out_beat_t in_beat,
    output logic                in_ready,
    output logic                out_valid,
    output eicr_pkg::out_beat_t out_beat,
    input  logic                out_ready
);

    import eicr_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_beat_t out_beat_reg;
    out_beat_t out_beat_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_beat_t skid_beat_reg;
    out_beat_t skid_beat_next;

    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_beat_next   = out_beat_reg;
        skid_valid_next = skid_valid_reg;
        skid_beat_next  = skid_beat_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_beat_next   = skid_beat_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_beat_next  = in_beat;
            end
        end else if (in_valid && in_ready) begin
            // output is stalled, park the transfer
            skid_valid_next = 1'b1;
            skid_beat_next  = in_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_beat_reg  <= out_beat_next;
        skid_beat_reg <= skid_beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

[rtl/core/elastic_impulse_collision_resolve.sv]
`timescale 1ns / 1ps
// channel   dir   handshake            contents
// s_        in    s_tvalid/s_tready    collision pair: velocities, masses, normal, depth
// m_        out   m_tvalid/m_tready    new velocities, position shifts, flags in m_tuser
//
// one pair accepted per cycle, except while the pipe holds for a full skid register
// the pipeline depth is set by two chained bit-per-stage dividers (effective mass, then
// impulse over mass) plus the multiply stages around them
// aresetn clears only the valid bits, including those of the output buffer
// a stalled output parks one result in a skid register; the whole pipe holds while it is full
module elastic_impulse_collision_resolve #(
    parameter int FRAC_BITS = eicr_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // vel_a_x, vel_a_y, mass_a, vel_b_x, vel_b_y, mass_b, normal_x, normal_y, depth, zero pad
    input  logic [eicr_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
    // shift_a_x, shift_a_y, shift_b_x, shift_b_y
    output logic [eicr_pkg::M_DATA_W-1:0] m_tdata,
    // impulse_applied, mass_error
    output logic [eicr_pkg::M_USER_W-1:0] m_tuser
);

    import eicr_pkg::*;

    localparam int F       = FRAC_BITS;
    localparam int N_STAGE = 70;
    localparam int SH_QW   = F + 1;
    localparam int PA_W    = F + 32;
    localparam int MAG_W   = 33;

    logic en;
    logic [N_STAGE-1:0] vld_reg;

    // input fields
    logic signed [31:0] in_vax, in_vay, in_vbx, in_vby;
    logic [30:0]        in_ma, in_mb, in_depth;
    logic signed [17:0] in_nx, in_ny;

    assign in_vax   = s_tdata[31:0];
    assign in_vay   = s_tdata[63:32];
    assign in_ma    = s_tdata[94:64];
    assign in_vbx   = s_tdata[126:95];
    assign in_vby   = s_tdata[158:127];
    assign in_mb    = s_tdata[189:159];
    assign in_nx    = s_tdata[207:190];
    assign in_ny    = s_tdata[225:208];
    assign in_depth = s_tdata[256:226];

    // stage 1
    logic signed [31:0] vax_s1_reg, vay_s1_reg, vbx_s1_reg, vby_s1_reg;
    logic [30:0]        ma_s1_reg, mb_s1_reg, depth_s1_reg;
    logic signed [17:0] nx_s1_reg, ny_s1_reg;
    logic [31:0]        tot_s1_reg, tot_s1_next;
    logic signed [32:0] dvx_s1_reg, dvy_s1_reg, dvx_s1_next, dvy_s1_next;
    logic               err_s1_reg, err_s1_next;

    assign tot_s1_next = {1'b0, in_ma} + {1'b0, in_mb};
    assign dvx_s1_next = in_vax - in_vbx;
    assign dvy_s1_next = in_vay - in_vby;
    assign err_s1_next = (in_ma == '0) || (in_mb == '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            vax_s1_reg   <= in_vax;
            vay_s1_reg   <= in_vay;
            vbx_s1_reg   <= in_vbx;
            vby_s1_reg   <= in_vby;
            ma_s1_reg    <= in_ma;
            mb_s1_reg    <= in_mb;
            depth_s1_reg <= in_depth;
            nx_s1_reg    <= in_nx;
            ny_s1_reg    <= in_ny;
            tot_s1_reg   <= tot_s1_next;
            dvx_s1_reg   <= dvx_s1_next;
            dvy_s1_reg   <= dvy_s1_next;
            err_s1_reg   <= err_s1_next;
        end
    end

    // stage 2: dot product terms and mass product
    logic signed [50:0] px_s2_reg, py_s2_reg, px_s2_next, py_s2_next;
    logic [61:0]        mamb_s2_reg, mamb_s2_next;
    logic [31:0]        tot_s2_reg;
    logic               err_s2_reg;

    assign px_s2_next   = dvx_s1_reg * nx_s1_reg;
    assign py_s2_next   = dvy_s1_reg * ny_s1_reg;
    assign mamb_s2_next = ma_s1_reg * mb_s1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            px_s2_reg   <= px_s2_next;
            py_s2_reg   <= py_s2_next;
            mamb_s2_reg <= mamb_s2_next;
            tot_s2_reg  <= tot_s1_reg;
            err_s2_reg  <= err_s1_reg;
        end
    end

    // stage 3: relative normal velocity
    logic signed [51:0] dot_s3;
    logic signed [51:0] dot_sh_s3;
    logic signed [31:0] vrel_s3_reg, vrel_s3_next;
    logic               hit_s3_reg, hit_s3_next;
    logic               err_s3_reg;

    assign dot_s3       = px_s2_reg + py_s2_reg;
    assign dot_sh_s3    = dot_s3 >>> F;
    assign vrel_s3_next = sat32(64'(dot_sh_s3));
    assign hit_s3_next  = !err_s2_reg && vrel_s3_next[31];

    always_ff @(posedge aclk) begin
        if (en) begin
            vrel_s3_reg <= vrel_s3_next;
            hit_s3_reg  <= hit_s3_next;
            err_s3_reg  <= err_s2_reg;
        end
    end

    // effective mass, ready at stage 33
    logic [30:0] meff_s33;

    eicr_div #(.NUM_W(62), .DEN_W(32), .QUO_W(31)) u_div_meff (
        .aclk (aclk),
        .en   (en),
        .num  (mamb_s2_reg),
        .den  (tot_s2_reg),
        .quo  (meff_s33)
    );

    logic [31:0] vrel_d;
    logic signed [31:0] vrel_s33;

    eicr_delay #(.WIDTH(32), .DEPTH(30)) u_dly_vrel (
        .aclk (aclk),
        .en   (en),
        .din  (vrel_s3_reg),
        .dout (vrel_d)
    );
    assign vrel_s33 = vrel_d;

    // stage 34: impulse magnitude product
    logic signed [33:0] neg2v_s33;
    logic [MAG_W-1:0]   neg2v_mag;
    logic [63:0]        p_s34_reg, p_s34_next;

    assign neg2v_s33  = (34'sd0 - 34'(vrel_s33)) <<< 1;
    assign neg2v_mag  = neg2v_s33[MAG_W-1:0];
    assign p_s34_next = neg2v_mag * meff_s33;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_s34_reg <= p_s34_next;
        end
    end

    // stage 35: scale and clamp j
    logic [63:0] p_sh_s34;
    logic [30:0] j_s35_reg, j_s35_next;

    assign p_sh_s34   = p_s34_reg >> F;
    assign j_s35_next = (|p_sh_s34[63:31]) ? 31'h7fff_ffff : p_sh_s34[30:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            j_s35_reg <= j_s35_next;
        end
    end

    // stage 36: impulse vector
    logic [35:0]        nrm_j_d;
    logic signed [17:0] nx_j, ny_j;
    logic signed [31:0] j_sgn;
    logic signed [49:0] jnx_s36_reg, jny_s36_reg, jnx_s36_next, jny_s36_next;

    eicr_delay #(.WIDTH(36), .DEPTH(34)) u_dly_nrm_j (
        .aclk (aclk),
        .en   (en),
        .din  ({nx_s1_reg, ny_s1_reg}),
        .dout (nrm_j_d)
    );
    assign nx_j = nrm_j_d[35:18];
    assign ny_j = nrm_j_d[17:0];

    assign j_sgn        = {1'b0, j_s35_reg};
    assign jnx_s36_next = j_sgn * nx_j;
    assign jny_s36_next = j_sgn * ny_j;

    always_ff @(posedge aclk) begin
        if (en) begin
            jnx_s36_reg <= jnx_s36_next;
            jny_s36_reg <= jny_s36_next;
        end
    end

    // stage 37: floor shift, then sign and magnitude for the divides
    logic signed [49:0] jx_sh, jy_sh;
    logic [49:0]        jx_abs, jy_abs;
    logic [MAG_W-1:0]   magx_s37_reg, magy_s37_reg;
    logic               sgnx_s37_reg, sgny_s37_reg;

    assign jx_sh  = jnx_s36_reg >>> F;
    assign jy_sh  = jny_s36_reg >>> F;
    assign jx_abs = jx_sh[49] ? -jx_sh : jx_sh;
    assign jy_abs = jy_sh[49] ? -jy_sh : jy_sh;

    always_ff @(posedge aclk) begin
        if (en) begin
            magx_s37_reg <= jx_abs[MAG_W-1:0];
            magy_s37_reg <= jy_abs[MAG_W-1:0];
            sgnx_s37_reg <= jx_sh[49];
            sgny_s37_reg <= jy_sh[49];
        end
    end

    logic [61:0] mass_d;
    logic [30:0] ma_s37, mb_s37;

    eicr_delay #(.WIDTH(62), .DEPTH(36)) u_dly_mass (
        .aclk (aclk),
        .en   (en),
        .din  ({ma_s1_reg, mb_s1_reg}),
        .dout (mass_d)
    );
    assign ma_s37 = mass_d[61:31];
    assign mb_s37 = mass_d[30:0];

    // velocity deltas, ready at stage 70
    logic [MAG_W+F-1:0] numx, numy;
    logic [MAG_W-1:0]   qa_x, qa_y, qb_x, qb_y;

    assign numx = {magx_s37_reg, {F{1'b0}}};
    assign numy = {magy_s37_reg, {F{1'b0}}};

    eicr_div #(.NUM_W(MAG_W + F), .DEN_W(31), .QUO_W(MAG_W)) u_div_ax (
        .aclk (aclk), .en (en), .num (numx), .den (ma_s37), .quo (qa_x)
    );
    eicr_div #(.NUM_W(MAG_W + F), .DEN_W(31), .QUO_W(MAG_W)) u_div_ay (
        .aclk (aclk), .en (en), .num (numy), .den (ma_s37), .quo (qa_y)
    );
    eicr_div #(.NUM_W(MAG_W + F), .DEN_W(31), .QUO_W(MAG_W)) u_div_bx (
        .aclk (aclk), .en (en), .num (numx), .den (mb_s37), .quo (qb_x)
    );
    eicr_div #(.NUM_W(MAG_W + F), .DEN_W(31), .QUO_W(MAG_W)) u_div_by (
        .aclk (aclk), .en (en), .num (numy), .den (mb_s37), .quo (qb_y)
    );

    logic [1:0] sgn_d;

    eicr_delay #(.WIDTH(2), .DEPTH(33)) u_dly_sgn (
        .aclk (aclk),
        .en   (en),
        .din  ({sgnx_s37_reg, sgny_s37_reg}),
        .dout (sgn_d)
    );

    // position correction path
    logic [SH_QW-1:0] sha_s, shb_s;
    logic [MASS_W+F-1:0] num_sha, num_shb;

    assign num_sha = {ma_s1_reg, {F{1'b0}}};
    assign num_shb = {mb_s1_reg, {F{1'b0}}};

    eicr_div #(.NUM_W(MASS_W + F), .DEN_W(32), .QUO_W(SH_QW)) u_div_sha (
        .aclk (aclk), .en (en), .num (num_sha), .den (tot_s1_reg), .quo (sha_s)
    );
    eicr_div #(.NUM_W(MASS_W + F), .DEN_W(32), .QUO_W(SH_QW)) u_div_shb (
        .aclk (aclk), .en (en), .num (num_shb), .den (tot_s1_reg), .quo (shb_s)
    );

    logic [30:0] depth_d;

    eicr_delay #(.WIDTH(31), .DEPTH(F + 1)) u_dly_depth (
        .aclk (aclk),
        .en   (en),
        .din  (depth_s1_reg),
        .dout (depth_d)
    );

    logic [PA_W-1:0] pa_reg, pb_reg, pa_next, pb_next;

    assign pa_next = depth_d * shb_s;
    assign pb_next = depth_d * sha_s;

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

    logic [30:0] ca_reg, cb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ca_reg <= pa_reg[F+30:F];
            cb_reg <= pb_reg[F+30:F];
        end
    end

    logic [35:0]        nrm_s_d;
    logic signed [17:0] nx_s, ny_s;
    logic signed [31:0] ca_sgn, cb_sgn;
    logic signed [49:0] nax_reg, nay_reg, nbx_reg, nby_reg;
    logic signed [49:0] nax_next, nay_next, nbx_next, nby_next;

    eicr_delay #(.WIDTH(36), .DEPTH(F + 3)) u_dly_nrm_s (
        .aclk (aclk),
        .en   (en),
        .din  ({nx_s1_reg, ny_s1_reg}),
        .dout (nrm_s_d)
    );
    assign nx_s = nrm_s_d[35:18];
    assign ny_s = nrm_s_d[17:0];

    assign ca_sgn   = {1'b0, ca_reg};
    assign cb_sgn   = {1'b0, cb_reg};
    assign nax_next = nx_s * ca_sgn;
    assign nay_next = ny_s * ca_sgn;
    assign nbx_next = nx_s * cb_sgn;
    assign nby_next = ny_s * cb_sgn;

    always_ff @(posedge aclk) begin
        if (en) begin
            nax_reg <= nax_next;
            nay_reg <= nay_next;
            nbx_reg <= nbx_next;
            nby_reg <= nby_next;
        end
    end

    logic signed [49:0] nax_sh, nay_sh, nbx_sh, nby_sh;
    logic signed [31:0] sax_reg, say_reg, sbx_reg, sby_reg;

    assign nax_sh = nax_reg >>> F;
    assign nay_sh = nay_reg >>> F;
    assign nbx_sh = nbx_reg >>> F;
    assign nby_sh = nby_reg >>> F;

    always_ff @(posedge aclk) begin
        if (en) begin
            sax_reg <= sat32(64'(nax_sh));
            say_reg <= sat32(64'(nay_sh));
            sbx_reg <= sat32(64'sd0 - 64'(nbx_sh));
            sby_reg <= sat32(64'sd0 - 64'(nby_sh));
        end
    end

    logic [127:0] shift_d;

    eicr_delay #(.WIDTH(128), .DEPTH(64 - F)) u_dly_shift (
        .aclk (aclk),
        .en   (en),
        .din  ({sby_reg, sbx_reg, say_reg, sax_reg}),
        .dout (shift_d)
    );

    // velocities and flags carried to stage 70
    logic [127:0] vel_d;
    logic [1:0]   flag_d;

    eicr_delay #(.WIDTH(128), .DEPTH(69)) u_dly_vel (
        .aclk (aclk),
        .en   (en),
        .din  ({vby_s1_reg, vbx_s1_reg, vay_s1_reg, vax_s1_reg}),
        .dout (vel_d)
    );

    eicr_delay #(.WIDTH(2), .DEPTH(67)) u_dly_flag (
        .aclk (aclk),
        .en   (en),
        .din  ({err_s3_reg, hit_s3_reg}),
        .dout (flag_d)
    );

    // stage 70 results
    logic signed [31:0] vax_d, vay_d, vbx_d, vby_d;
    logic               hit_d, err_d;
    logic signed [34:0] qax_e, qay_e, qbx_e, qby_e;
    logic signed [34:0] qax_s, qay_s, qbx_s, qby_s;
    logic signed [34:0] sum_ax, sum_ay, sum_bx, sum_by;
    logic signed [31:0] nvax, nvay, nvbx, nvby;
    logic [127:0]       shift_out;
    out_beat_t          res_beat;
    out_beat_t          out_beat;

    assign vax_d = vel_d[31:0];
    assign vay_d = vel_d[63:32];
    assign vbx_d = vel_d[95:64];
    assign vby_d = vel_d[127:96];
    assign hit_d = flag_d[0];
    assign err_d = flag_d[1];

    assign qax_e = {2'b00, qa_x};
    assign qay_e = {2'b00, qa_y};
    assign qbx_e = {2'b00, qb_x};
    assign qby_e = {2'b00, qb_y};
    assign qax_s = sgn_d[1] ? -qax_e : qax_e;
    assign qay_s = sgn_d[0] ? -qay_e : qay_e;
    assign qbx_s = sgn_d[1] ? -qbx_e : qbx_e;
    assign qby_s = sgn_d[0] ? -qby_e : qby_e;

    assign sum_ax = 35'(vax_d) + qax_s;
    assign sum_ay = 35'(vay_d) + qay_s;
    assign sum_bx = 35'(vbx_d) - qbx_s;
    assign sum_by = 35'(vby_d) - qby_s;

    assign nvax = hit_d ? sat32(64'(sum_ax)) : vax_d;
    assign nvay = hit_d ? sat32(64'(sum_ay)) : vay_d;
    assign nvbx = hit_d ? sat32(64'(sum_bx)) : vbx_d;
    assign nvby = hit_d ? sat32(64'(sum_by)) : vby_d;

    assign shift_out = err_d ? '0 : shift_d;

    always_comb begin
        res_beat                = '0;
        res_beat.data           = {shift_out, nvby, nvbx, nvay, nvax};
        res_beat.user[USER_HIT] = hit_d;
        res_beat.user[USER_ERR] = err_d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N_STAGE-2:0], s_tvalid};
        end
    end

    eicr_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[N_STAGE-1]),
        .in_beat   (res_beat),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_beat  (out_beat),
        .out_ready (m_tready)
    );

    assign s_tready = en;
    assign m_tdata  = out_beat.data;
    assign m_tuser  = out_beat.user;

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[USER_HIT] && m_tuser[USER_ERR]))
        else $error("impulse and mass error flagged together");

    a_err_zero_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[USER_ERR]) |-> (m_tdata[255:128] == '0))
        else $error("shift nonzero on mass error");

    a_stall_only_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && $past(m_tvalid && !m_tready)))
        else $error("pipe stalled without a held result");

endmodule
